// ----- rtl/msc_pkg.sv -----
// shared constants and types for the minimum square count core
// no dependencies; imported by msc_seq and the top level
package msc_pkg;

    // largest target kept in the scratch table
    localparam int MAX_N       = 1023;
    // width of the incoming target field
    localparam int N_W         = 10;
    // width of a table entry and of the result
    localparam int COUNT_W     = 3;
    // targets up to this value answer themselves
    localparam int SMALL_LIMIT = 3;

    localparam int ADDR_W = $clog2(MAX_N + 1);
    // running square x*x may pass i by one odd step
    localparam int SQ_W   = ADDR_W + 1;
    // odd increment 2x+1, x up to about sqrt(MAX_N)+1
    localparam int ODD_W  = (ADDR_W + 1) / 2 + 2;
    // working minimum, wide enough for 1 + largest entry
    localparam int BEST_W = COUNT_W + 1;
    // counter over the seed entries 0..SMALL_LIMIT
    localparam int INIT_W = $clog2(SMALL_LIMIT + 1);
    // no target ever needs more than four squares
    localparam int MAX_COUNT = 4;

    // table access request from the sequencer
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COUNT_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } msc_mem_req_t;

    // finished answer handed to the output register
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } msc_res_t;

endpackage

// ----- rtl/msc_ram.sv -----
// generic single-clock ram, one write port and one read port
// read data registered; no package dependency
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/msc_seq.sv -----
// sequencer: answers small targets directly; otherwise seeds the scratch table, then fills it bottom-up
// depends on msc_pkg; drives the table ram through an msc_mem_req_t
module msc_seq
    import msc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [N_W-1:0]     n_value,
    input  logic               out_free,
    output msc_res_t           res,
    output msc_mem_req_t       mem,
    input  logic [COUNT_W-1:0] rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_WRITE,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   n_reg;
    logic [ADDR_W-1:0]   i_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [ODD_W-1:0]    odd_reg;
    logic [BEST_W-1:0]   best_reg;
    logic                pend_reg;
    logic [INIT_W-1:0]   ctr_reg;
    logic [COUNT_W-1:0]  ans_reg;

    logic [ADDR_W-1:0]   n_sat;
    logic [BEST_W-1:0]   cand;
    logic [BEST_W-1:0]   folded;
    logic                issue;

    // clamp target to the table size
    always_comb begin
        if (32'(n_value) > MAX_N) begin
            n_sat = ADDR_W'(MAX_N);
        end else begin
            n_sat = ADDR_W'(n_value);
        end
    end

    // fold the entry read last cycle into the running minimum
    assign cand   = BEST_W'(rd_data) + BEST_W'(1);
    assign folded = (pend_reg && (cand < best_reg)) ? cand : best_reg;

    // a read goes out while x*x <= i
    assign issue = (state_reg == S_SCAN) && (sq_reg <= {1'b0, i_reg});

    // table port
    always_comb begin
        mem.raddr = ADDR_W'({1'b0, i_reg} - sq_reg);
        mem.we    = (state_reg == S_INIT) || (state_reg == S_WRITE);
        if (state_reg == S_INIT) begin
            mem.waddr = ADDR_W'(ctr_reg);
            mem.wdata = COUNT_W'(ctr_reg);
        end else begin
            mem.waddr = i_reg;
            mem.wdata = COUNT_W'(best_reg);
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT) && out_free;
    assign res.count = ans_reg;

    // control state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    pend_reg <= 1'b0;
                    if (s_valid) begin
                        n_reg <= n_sat;
                        if (n_sat <= ADDR_W'(SMALL_LIMIT)) begin
                            ans_reg   <= COUNT_W'(n_sat);
                            state_reg <= S_OUT;
                        end else begin
                            ctr_reg   <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    ctr_reg <= ctr_reg + INIT_W'(1);
                    if (ctr_reg == INIT_W'(SMALL_LIMIT)) begin
                        i_reg     <= ADDR_W'(SMALL_LIMIT + 1);
                        sq_reg    <= SQ_W'(1);
                        odd_reg   <= ODD_W'(3);
                        // x = 1 candidate always lowers an all-ones start
                        best_reg  <= '1;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    best_reg <= folded;
                    pend_reg <= issue;
                    if (issue) begin
                        sq_reg  <= sq_reg + SQ_W'(odd_reg);
                        odd_reg <= odd_reg + ODD_W'(2);
                    end else begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    pend_reg <= 1'b0;
                    if (i_reg == n_reg) begin
                        ans_reg   <= COUNT_W'(best_reg);
                        state_reg <= S_OUT;
                    end else begin
                        i_reg     <= i_reg + ADDR_W'(1);
                        sq_reg    <= SQ_W'(1);
                        odd_reg   <= ODD_W'(3);
                        best_reg  <= '1;
                        state_reg <= S_SCAN;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // reads only reach entries below the one being built
    a_read_below: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (mem.raddr < i_reg))
        else $error("table read at or above current entry");

    // a stored entry never exceeds four squares
    a_entry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (best_reg <= BEST_W'(MAX_COUNT)))
        else $error("table entry above four");

    // every read issued is folded in the following cycle
    a_fold_next: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> pend_reg)
        else $error("issued read not folded");

    // the sequencer takes no transaction while an answer is pending
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !s_ready)
        else $error("accept while answer pending");
`endif

endmodule

// ----- rtl/min_square_count_dp_core.sv -----
// top level of the minimum square count core
// depends on msc_pkg, msc_seq and msc_ram
//
// Answers, for each target n on s_n_value, the least number of perfect
// squares that sum to n (0..4). Targets 0..3 answer directly.
// Larger targets seed entries 0..3 of a 1024 x 3 scratch ram, then build
// each entry i from 4 to n, one table read a cycle through the single
// read port. One transaction is worked on at a time; the answer sits in an
// output register, and the next target is taken as soon as it has been
// handed over to that register.
module min_square_count_dp_core
    import msc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [N_W-1:0]     s_n_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_min_count
);

    msc_mem_req_t        mem;
    msc_res_t            res;
    logic [COUNT_W-1:0]  rd_data;
    logic                out_free;

    logic                m_valid_reg;
    logic [COUNT_W-1:0]  m_min_count_reg;

    // sequencer
    msc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .n_value  (s_n_value),
        .out_free (out_free),
        .res      (res),
        .mem      (mem),
        .rd_data  (rd_data)
    );

    // scratch table
    msc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_N + 1)
    ) u_table (
        .aclk  (aclk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rd_data)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg     <= 1'b1;
            m_min_count_reg <= res.count;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_min_count = m_min_count_reg;

endmodule
